// File: hdl/pli_pkg.sv
`timescale 1ns / 1ps

package pli_pkg;

    localparam int DATA_W  = 16;
    localparam int COUNT_W = 5;
    localparam int ADDR_W  = 3;
    localparam int MAG_W   = 16;
    localparam int PROD_W  = 32;
    localparam int QUOT_W  = 17;
    localparam int NUM_W   = 33;
    localparam int DEN_W   = 17;

    localparam logic [COUNT_W-1:0] COUNT_RESET = 5'd2;

    // register index, taken from paddr[2]
    localparam logic REG_POINT_COUNT = 1'b0;

    localparam logic MODE_WRITE = 1'b0;
    localparam logic MODE_EVAL  = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LAST,
        S_FIRST,
        S_SCAN,
        S_MUL,
        S_START,
        S_DIV,
        S_FIN
    } state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

// File: hdl/piecewise_linear_interpolator_unit.sv
`timescale 1ns / 1ps
// Write transactions leave the block in idle, so it stays ready for the next transaction.
// Evaluate transactions run through the states LAST, FIRST, SCAN, MUL, START, DIV and FIN:
// a one-entry-per-cycle segment scan through the breakpoint RAM read port,
// one multiply, then the bit-serial divider (skipped for a zero span).
// One evaluation in flight at a time; a finished result waits in the output register.
// rst_n is asynchronous, active low: clears control and point_count to 2; RAM is not cleared.
module piecewise_linear_interpolator_unit #(
    parameter int MAX_POINTS = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic                                mode,
    input  logic [3:0]                          point_index,
    input  logic signed [pli_pkg::DATA_W-1:0]   point_x,
    input  logic signed [pli_pkg::DATA_W-1:0]   point_y,
    input  logic signed [pli_pkg::DATA_W-1:0]   query_t,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic signed [pli_pkg::DATA_W-1:0]   value,
    output logic                                extrapolated,
    output logic                                saturated,
    output logic                                zero_span,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [pli_pkg::ADDR_W-1:0]          paddr,
    input  logic [31:0]                         pwdata,
    output logic [31:0]                         prdata,
    output logic                                pready
);

    localparam int AW = $clog2(MAX_POINTS);
    localparam int DW = pli_pkg::DATA_W;
    localparam int MW = pli_pkg::MAG_W;
    localparam int CW = pli_pkg::COUNT_W;

    pli_pkg::state_t state_reg, state_next;

    logic [CW-1:0]        cnt_reg;
    logic                 out_valid_reg;
    logic signed [DW-1:0] value_reg;
    logic                 ext_reg;
    logic                 sat_reg;
    logic                 zs_out_reg;

    logic signed [DW-1:0] t_reg;
    logic [AW-1:0]        last_idx_reg;
    logic [AW-1:0]        scan_idx_reg;
    logic signed [DW-1:0] prev_x_reg, prev_y_reg;
    logic                 le_prev_reg;
    logic                 le0_reg;
    logic                 lt0_reg;
    logic                 gt_last_reg;
    logic signed [DW-1:0] x0_reg, y0_reg, x1_reg, y1_reg;
    logic [pli_pkg::PROD_W-1:0] prod_reg;
    logic [MW-1:0]        span_reg;
    logic                 neg_reg;
    logic                 zs_reg;

    logic                 in_accept;
    logic                 ram_we;
    logic [AW-1:0]        ram_raddr;
    logic [2*DW-1:0]      ram_rdata;
    logic signed [DW-1:0] rd_x, rd_y;
    logic [AW-1:0]        last_idx_c;
    logic                 le_c;
    logic                 found_c;
    logic                 scan_end_c;
    logic                 load_seg_c;

    logic signed [DW:0]   dt_c, dx_c, dy_c;
    logic signed [DW:0]   dt_n, dx_n, dy_n;
    logic [MW-1:0]        dt_mag, dx_mag, dy_mag;

    logic                 div_start;
    logic [pli_pkg::NUM_W-1:0]  div_num;
    logic [pli_pkg::DEN_W-1:0]  div_den;
    logic [pli_pkg::QUOT_W-1:0] div_quot;
    pli_pkg::div_stat_t   div_stat;

    logic signed [DW+2:0] sq_c, sum_c;
    logic                 clip_c;
    logic signed [DW-1:0] fin_value_c;
    logic                 out_load;

    assign in_accept = in_valid && !in_stall;
    assign in_stall  = (state_reg != pli_pkg::S_IDLE);
    assign ram_we    = in_accept && (mode == pli_pkg::MODE_WRITE)
                       && (int'(point_index) < MAX_POINTS);

    always_comb
    begin
        if (cnt_reg < 5'd2)
        begin
            last_idx_c = AW'(1);
        end
        else if (int'(cnt_reg) > MAX_POINTS)
        begin
            last_idx_c = AW'(MAX_POINTS - 1);
        end
        else
        begin
            last_idx_c = AW'(cnt_reg - 5'd1);
        end
    end

    always_comb
    begin
        unique case (state_reg)
            pli_pkg::S_LAST:  ram_raddr = last_idx_reg;
            pli_pkg::S_SCAN:  ram_raddr = scan_idx_reg + AW'(1);
            default:          ram_raddr = '0;
        endcase
    end

    pli_ram #(
        .WIDTH (2 * DW),
        .DEPTH (MAX_POINTS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (AW'(point_index)),
        .wdata ({point_x, point_y}),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign rd_x = ram_rdata[2*DW-1:DW];
    assign rd_y = ram_rdata[DW-1:0];

    // the one ordering comparator: t <= x of the entry just read
    assign le_c       = t_reg <= rd_x;
    assign found_c    = !le_prev_reg && le_c;
    assign scan_end_c = (scan_idx_reg != '0) && (found_c || scan_idx_reg == last_idx_reg);
    // segment 0 is captured at index 1 and kept unless a later one is chosen
    assign load_seg_c = (scan_idx_reg == AW'(1)) || found_c
                        || (scan_idx_reg == last_idx_reg && !le0_reg);

    assign dt_c = {t_reg[DW-1], t_reg} - {x0_reg[DW-1], x0_reg};
    assign dx_c = {x1_reg[DW-1], x1_reg} - {x0_reg[DW-1], x0_reg};
    assign dy_c = {y1_reg[DW-1], y1_reg} - {y0_reg[DW-1], y0_reg};
    assign dt_n = -dt_c;
    assign dx_n = -dx_c;
    assign dy_n = -dy_c;
    assign dt_mag = dt_c[DW] ? dt_n[MW-1:0] : dt_c[MW-1:0];
    assign dx_mag = dx_c[DW] ? dx_n[MW-1:0] : dx_c[MW-1:0];
    assign dy_mag = dy_c[DW] ? dy_n[MW-1:0] : dy_c[MW-1:0];

    // round half away from zero: (2|num| + |dx|) / (2|dx|)
    assign div_start = (state_reg == pli_pkg::S_START) && !zs_reg;
    assign div_num   = pli_pkg::NUM_W'({prod_reg, 1'b0}) + pli_pkg::NUM_W'(span_reg);
    assign div_den   = {span_reg, 1'b0};

    pli_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .quot  (div_quot),
        .stat  (div_stat)
    );

    assign sq_c   = neg_reg ? -$signed({2'b00, div_quot}) : $signed({2'b00, div_quot});
    assign sum_c  = {{3{y0_reg[DW-1]}}, y0_reg} + sq_c;
    assign clip_c = !zs_reg && (sum_c[DW+2:DW-1] != '0) && (sum_c[DW+2:DW-1] != '1);

    always_comb
    begin
        if (zs_reg)
        begin
            fin_value_c = y0_reg;
        end
        else if (clip_c)
        begin
            fin_value_c = sum_c[DW+2] ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
        end
        else
        begin
            fin_value_c = sum_c[DW-1:0];
        end
    end

    assign out_load = (state_reg == pli_pkg::S_FIN) && (!out_valid_reg || !out_stall);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            pli_pkg::S_IDLE:
            begin
                if (in_accept && mode == pli_pkg::MODE_EVAL)
                begin
                    state_next = pli_pkg::S_LAST;
                end
            end
            pli_pkg::S_LAST:  state_next = pli_pkg::S_FIRST;
            pli_pkg::S_FIRST: state_next = pli_pkg::S_SCAN;
            pli_pkg::S_SCAN:
            begin
                if (scan_end_c)
                begin
                    state_next = pli_pkg::S_MUL;
                end
            end
            pli_pkg::S_MUL:   state_next = pli_pkg::S_START;
            pli_pkg::S_START: state_next = zs_reg ? pli_pkg::S_FIN : pli_pkg::S_DIV;
            pli_pkg::S_DIV:
            begin
                if (div_stat.done)
                begin
                    state_next = pli_pkg::S_FIN;
                end
            end
            pli_pkg::S_FIN:
            begin
                if (out_load)
                begin
                    state_next = pli_pkg::S_IDLE;
                end
            end
            default:          state_next = pli_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= pli_pkg::S_IDLE;
            cnt_reg       <= pli_pkg::COUNT_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (psel && penable && pwrite && paddr[2] == pli_pkg::REG_POINT_COUNT)
            begin
                cnt_reg <= pwdata[CW-1:0];
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            pli_pkg::S_IDLE:
            begin
                if (in_accept)
                begin
                    t_reg        <= query_t;
                    last_idx_reg <= last_idx_c;
                end
            end
            pli_pkg::S_FIRST:
            begin
                gt_last_reg  <= !le_c;
                scan_idx_reg <= '0;
            end
            pli_pkg::S_SCAN:
            begin
                scan_idx_reg <= scan_idx_reg + AW'(1);
                prev_x_reg   <= rd_x;
                prev_y_reg   <= rd_y;
                le_prev_reg  <= le_c;
                if (scan_idx_reg == '0)
                begin
                    le0_reg <= le_c;
                    lt0_reg <= le_c && (t_reg != rd_x);
                end
                else if (load_seg_c)
                begin
                    x0_reg <= prev_x_reg;
                    y0_reg <= prev_y_reg;
                    x1_reg <= rd_x;
                    y1_reg <= rd_y;
                end
            end
            pli_pkg::S_MUL:
            begin
                prod_reg <= dt_mag * dy_mag;
                span_reg <= dx_mag;
                neg_reg  <= dt_c[DW] ^ dy_c[DW] ^ dx_c[DW];
                zs_reg   <= (dx_c == '0);
            end
            pli_pkg::S_FIN:
            begin
                if (out_load)
                begin
                    value_reg  <= fin_value_c;
                    ext_reg    <= lt0_reg || gt_last_reg;
                    sat_reg    <= clip_c;
                    zs_out_reg <= zs_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign out_valid    = out_valid_reg;
    assign value        = value_reg;
    assign extrapolated = ext_reg;
    assign saturated    = sat_reg;
    assign zero_span    = zs_out_reg;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == pli_pkg::REG_POINT_COUNT) ? 32'(cnt_reg) : '0;

`ifndef SYNTHESIS
    a_div_in_div_state: assert property (@(posedge clk) disable iff (!rst_n)
        div_stat.busy |-> state_reg == pli_pkg::S_DIV)
        else $error("divider busy outside divide state");

    a_eval_starts_scan: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && mode == pli_pkg::MODE_EVAL) |=> state_reg == pli_pkg::S_LAST)
        else $error("evaluate transaction did not start a search");

    a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == pli_pkg::S_SCAN |-> scan_idx_reg <= last_idx_reg)
        else $error("scan index past last breakpoint");

    a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(zs_out_reg && sat_reg))
        else $error("zero span result marked saturated");
`endif

endmodule

// File: hdl/pli_ram.sv
`timescale 1ns / 1ps

module pli_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: hdl/pli_div.sv
`timescale 1ns / 1ps

// Restoring divider, one quotient bit per cycle. The quotient is clamped to
// all ones when it would not fit in QUOT_W bits.
module pli_div (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [pli_pkg::NUM_W-1:0]      num,
    input  logic [pli_pkg::DEN_W-1:0]      den,
    output logic [pli_pkg::QUOT_W-1:0]     quot,
    output pli_pkg::div_stat_t             stat
);

    localparam int QW = pli_pkg::QUOT_W;
    localparam int DW = pli_pkg::DEN_W;
    localparam int CW = $clog2(QW + 1);

    logic          busy_reg;
    logic          done_reg;
    logic [CW-1:0] cnt_reg;
    logic [DW-1:0] den_reg;
    logic [DW-1:0] rem_reg;
    logic [QW-1:0] nlow_reg;
    logic [QW-1:0] quot_reg;
    logic          ovf;
    logic [DW:0]   trial;
    logic [DW:0]   diff;
    logic          fits;

    // quotient overflows when the top numerator bits already reach den
    assign ovf   = {1'b0, num[pli_pkg::NUM_W-1:QW]} >= den;
    assign trial = {rem_reg, nlow_reg[QW-1]};
    assign diff  = trial - {1'b0, den_reg};
    assign fits  = trial >= {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= !ovf;
            done_reg <= ovf;
            cnt_reg  <= CW'(QW);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - CW'(1);
            if (cnt_reg == CW'(1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            den_reg  <= den;
            rem_reg  <= {1'b0, num[pli_pkg::NUM_W-1:QW]};
            nlow_reg <= num[QW-1:0];
            quot_reg <= ovf ? '1 : '0;
        end
        else if (busy_reg)
        begin
            rem_reg  <= fits ? diff[DW-1:0] : trial[DW-1:0];
            quot_reg <= {quot_reg[QW-2:0], fits};
            nlow_reg <= {nlow_reg[QW-2:0], 1'b0};
        end
    end

    assign quot      = quot_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

// File: sim/tb_piecewise_linear_interpolator_unit.sv
`timescale 1ns / 1ps

module tb_piecewise_linear_interpolator_unit;
    import pli_pkg::*;

    localparam int NPTS          = 16;
    localparam int RESET_CYCLES  = 12;
    localparam int SETTLE_CYCLES = 64;    // outlasts the longest evaluate at 16 points
    localparam int HOLD_CYCLES   = 400;
    localparam int STUCK_LIMIT   = 4000;
    localparam int PHASE_ITEMS   = 95;
    localparam int FILL_ITEMS    = 25;
    localparam int MAX_PRINTS    = 100;

    localparam logic [ADDR_W-1:0] ADDR_POINT_COUNT = {REG_POINT_COUNT, 2'b00};
    localparam logic [ADDR_W-1:0] ADDR_UNMAPPED    = 3'd4;

    typedef struct packed {
        logic signed [DATA_W-1:0] value;
        logic                     ext;
        logic                     sat;
        logic                     zs;
    } interp_res_t;

    typedef struct packed {
        logic                     mode;
        logic [3:0]               idx;
        logic signed [DATA_W-1:0] px;
        logic signed [DATA_W-1:0] py;
        logic signed [DATA_W-1:0] qt;
        logic                     typed;
        interp_res_t              want;
    } pli_item_t;

    typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_e;

    typedef struct packed {
        row_kind_e         kind;
        pli_item_t         item;
        logic [ADDR_W-1:0] addr;
        logic [4:0]        cnt;
    } dir_row_t;

    typedef enum logic [1:0] {PAT_FREE, PAT_LIGHT, PAT_HALF, PAT_HEAVY} stall_pat_e;

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     in_valid = 1'b0;
    logic                     in_stall;
    logic                     mode = MODE_WRITE;
    logic [3:0]               point_index = '0;
    logic signed [DATA_W-1:0] point_x = '0;
    logic signed [DATA_W-1:0] point_y = '0;
    logic signed [DATA_W-1:0] query_t = '0;
    logic                     out_valid;
    logic                     out_stall = 1'b0;
    logic signed [DATA_W-1:0] value;
    logic                     extrapolated;
    logic                     saturated;
    logic                     zero_span;
    logic                     psel = 1'b0;
    logic                     penable = 1'b0;
    logic                     pwrite = 1'b0;
    logic [ADDR_W-1:0]        paddr = '0;
    logic [31:0]              pwdata = '0;
    logic [31:0]              prdata;
    logic                     pready;

    // side band that travels with the payload: typed-in expectation of a directed row
    logic                     row_typed = 1'b0;
    interp_res_t              row_want = '0;

    logic [COUNT_W-1:0] cfg_count = COUNT_RESET;
    int                 tab_x [NPTS];
    int                 tab_y [NPTS];
    int                 gen_x [NPTS];
    int                 gen_y [NPTS];
    interp_res_t        res_q [$];
    dir_row_t           dir_rows [$];
    logic [COUNT_W-1:0] phase_counts [12] = '{16, 31, 1, 5, 17, 2, 0, 9, 3, 12, 16, 7};
    int                 err_cnt = 0;
    int                 stuck = 0;
    int                 burst_left = 0;
    bit                 fill_mode = 1'b0;
    bit                 hold_req = 1'b0;

    piecewise_linear_interpolator_unit #(.MAX_POINTS(NPTS)) dut (.*);

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    task automatic flag_mismatch(input string what, input logic signed [31:0] got,
                                 input logic signed [31:0] want);
        if (err_cnt < MAX_PRINTS)
            $display("%0t: %s mismatch, got %0d, expected %0d", $time, what, got, want);
        err_cnt++;
    endtask

    function automatic int eff_count(input logic [COUNT_W-1:0] c);
        if (c < 2)
            return 2;
        if (c > NPTS)
            return NPTS;
        return c;
    endfunction

    function automatic int clamp16(input int v);
        if (v > 32767)
            return 32767;
        if (v < -32768)
            return -32768;
        return v;
    endfunction

    // first segment with x[i] < t <= x[i+1], else the end segment; rounded, saturated
    function automatic interp_res_t interpolate(input logic signed [DATA_W-1:0] q);
        interp_res_t r;
        int          n, seg, i, t;
        bit          hit;
        longint      dx, dt, dy, num, an, ad, quo, v;
        n = eff_count(cfg_count);
        t = q;
        seg = 0;
        hit = 1'b0;
        for (i = 0; i + 1 < n; i++)
            if (!hit && tab_x[i] < t && t <= tab_x[i+1])
            begin
                seg = i;
                hit = 1'b1;
            end
        if (!hit)
            seg = (t <= tab_x[0]) ? 0 : n - 2;
        r = '0;
        r.ext = (t < tab_x[0]) || (t > tab_x[n-1]);
        dx = tab_x[seg+1] - tab_x[seg];
        if (dx == 0)
        begin
            r.zs = 1'b1;
            v = tab_y[seg];
        end
        else
        begin
            dt = t - tab_x[seg];
            dy = tab_y[seg+1] - tab_y[seg];
            num = dt * dy;
            an = (num < 0) ? -num : num;
            ad = (dx < 0) ? -dx : dx;
            quo = (2 * an + ad) / (2 * ad);    // ties away from zero
            v = tab_y[seg] + (((num < 0) != (dx < 0)) ? -quo : quo);
            if (v > 32767)
            begin
                v = 32767;
                r.sat = 1'b1;
            end
            else if (v < -32768)
            begin
                v = -32768;
                r.sat = 1'b1;
            end
        end
        r.value = v[DATA_W-1:0];
        return r;
    endfunction

    always @(posedge clk)
    begin : check_results
        interp_res_t w;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (res_q.size() == 0)
                    flag_mismatch("unexpected result, value", value, 0);
                else
                begin
                    w = res_q.pop_front();
                    if (value !== w.value)
                        flag_mismatch("value", value, w.value);
                    if (extrapolated !== w.ext)
                        flag_mismatch("extrapolated", extrapolated, w.ext);
                    if (saturated !== w.sat)
                        flag_mismatch("saturated", saturated, w.sat);
                    if (zero_span !== w.zs)
                        flag_mismatch("zero_span", zero_span, w.zs);
                end
            end
            if (in_valid && !in_stall)
            begin
                if (mode == MODE_WRITE)
                begin
                    tab_x[point_index] = point_x;
                    tab_y[point_index] = point_y;
                end
                else
                    res_q.push_back(row_typed ? row_want : interpolate(query_t));
            end
            if ((in_valid && !in_stall) || (out_valid && !out_stall) || psel)
                stuck = 0;
            else
                stuck++;
            if (stuck >= STUCK_LIMIT)
            begin
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    initial
    begin : receiver
        stall_pat_e pat;
        int         len;
        forever
        begin
            if (hold_req)
            begin
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
            end
            else
            begin
                pat = stall_pat_e'($urandom_range(0, 3));
                len = $urandom_range(16, 160);
                repeat (len)
                begin
                    case (pat)
                        PAT_FREE:  out_stall <= 1'b0;
                        PAT_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
                        PAT_HALF:  out_stall <= $urandom_range(0, 1);
                        default:   out_stall <= ($urandom_range(0, 4) != 0);
                    endcase
                    @(posedge clk);
                    if (hold_req)
                        break;
                end
            end
        end
    end

    task automatic send_item(input pli_item_t it);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0 || fill_mode) ? 0 : $urandom_range(1, 12);
            if (gap != 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_valid    <= 1'b1;
        mode        <= it.mode;
        point_index <= it.idx;
        point_x     <= it.px;
        point_y     <= it.py;
        query_t     <= it.qt;
        row_typed   <= it.typed;
        row_want    <= it.want;
        do @(posedge clk); while (in_stall);
    endtask

    // wait out every pending result, then the block's own latency
    task automatic settle();
        in_valid <= 1'b0;
        burst_left = 0;
        while (res_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_count(input logic [ADDR_W-1:0] addr, input logic [4:0] cnt);
        logic [31:0] junk;
        junk = $urandom();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= {junk[31:5], cnt};
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        if (addr == ADDR_POINT_COUNT)
            cfg_count = cnt;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
        psel    <= 1'b1;
        pwrite  <= 1'b0;
        paddr   <= ADDR_POINT_COUNT;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        if (prdata !== {27'd0, cfg_count})
            flag_mismatch("point_count readback", prdata, cfg_count);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    function automatic pli_item_t blank_item(input logic m);
        pli_item_t it;
        it.mode  = m;
        it.idx   = $urandom();
        it.px    = $urandom();
        it.py    = $urandom();
        it.qt    = $urandom();
        it.typed = 1'b0;
        it.want  = '0;
        return it;
    endfunction

    function automatic void row_point(input int idx, input int x, input int y);
        dir_row_t r;
        r = '0;
        r.kind = ROW_ITEM;
        r.item = blank_item(MODE_WRITE);
        r.item.idx = idx;
        r.item.px = x;
        r.item.py = y;
        dir_rows.push_back(r);
    endfunction

    function automatic void row_query(input int t);
        dir_row_t r;
        r = '0;
        r.kind = ROW_ITEM;
        r.item = blank_item(MODE_EVAL);
        r.item.qt = t;
        dir_rows.push_back(r);
    endfunction

    function automatic void row_check(input int t, input int v, input bit e, input bit s,
                                      input bit z);
        dir_row_t r;
        r = '0;
        r.kind = ROW_ITEM;
        r.item = blank_item(MODE_EVAL);
        r.item.qt = t;
        r.item.typed = 1'b1;
        r.item.want.value = v;
        r.item.want.ext = e;
        r.item.want.sat = s;
        r.item.want.zs = z;
        dir_rows.push_back(r);
    endfunction

    function automatic void row_cfg(input logic [ADDR_W-1:0] addr, input int cnt);
        dir_row_t r;
        r = '0;
        r.kind = ROW_CFG;
        r.addr = addr;
        r.cnt = cnt;
        dir_rows.push_back(r);
    endfunction

    // mostly order-keeping rewrites, and queries near breakpoints or in range; some noise
    function automatic pli_item_t random_item(input int n);
        pli_item_t it;
        int        i, k, lo, hi;
        if ($urandom_range(0, 99) < 35)
        begin
            it = blank_item(MODE_WRITE);
            i = it.idx;
            k = $urandom_range(0, 9);
            if (k < 7)
            begin
                lo = (i == 0) ? -32768 : gen_x[i-1] + 1;
                hi = (i == NPTS - 1) ? 32767 : gen_x[i+1] - 1;
                it.px = (lo <= hi) ? lo + int'($urandom_range(0, hi - lo)) : gen_x[i];
            end
            else if (k < 8)
                it.px = (i == 0) ? gen_x[1] : gen_x[i-1];    // duplicate abscissa
            k = $urandom_range(0, 9);
            if (k < 2)
                it.py = ($urandom_range(0, 1) != 0) ? 16'sh7FFF : 16'sh8000;
            else if (k < 5)
                it.py = int'($urandom_range(0, 8191)) - 4096;
            gen_x[i] = it.px;
            gen_y[i] = it.py;
        end
        else
        begin
            it = blank_item(MODE_EVAL);
            k = $urandom_range(0, 19);
            i = $urandom_range(0, n - 1);
            if (k < 7)
                it.qt = clamp16(gen_x[i] + int'($urandom_range(0, 2)) - 1);
            else if (k < 14 && gen_x[n-1] >= gen_x[0])
                it.qt = gen_x[0] + int'($urandom_range(0, gen_x[n-1] - gen_x[0]));
            else if (k < 16)
                it.qt = clamp16(gen_x[0] - int'($urandom_range(1, 64)));
            else if (k < 18)
                it.qt = clamp16(gen_x[n-1] + int'($urandom_range(1, 64)));
            else if (k == 18)
                it.qt = ($urandom_range(0, 1) != 0) ? 16'sh7FFF : 16'sh8000;
        end
        return it;
    endfunction

    // fresh strictly increasing table over all entries
    task automatic load_breakpoints();
        pli_item_t it;
        int        step_max, xv, i;
        bit        wide_y;
        case ($urandom_range(0, 2))
            0:       step_max = 4000;
            1:       step_max = 300;
            default: step_max = 3;
        endcase
        wide_y = $urandom_range(0, 1);
        xv = -32768 + int'($urandom_range(0, 65535 - 15 * step_max));
        for (i = 0; i < NPTS; i++)
        begin
            if (i != 0)
                xv += int'($urandom_range(1, step_max));
            it = blank_item(MODE_WRITE);
            it.idx = i;
            it.px = xv;
            if (!wide_y)
                it.py = int'($urandom_range(0, 8191)) - 4096;
            gen_x[i] = it.px;
            gen_y[i] = it.py;
            send_item(it);
        end
    endtask

    initial
    begin : stimulus
        dir_row_t r;
        int       p, k;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // full-range line, ends exact
        row_point(0, -32768, -32768);
        row_point(1, 32767, 32767);
        row_check(-32768, -32768, 0, 0, 0);
        row_check(32767, 32767, 0, 0, 0);
        row_query(0);
        row_query(-129);
        // collapsed segment
        row_point(1, -32768, 5);
        row_check(100, -32768, 1, 0, 1);
        // steepest slope, clipping both ways
        row_point(0, 0, 32767);
        row_point(1, 1, -32768);
        row_check(-100, 32767, 1, 1, 0);
        row_check(200, -32768, 1, 1, 0);
        row_check(1, -32768, 0, 0, 0);
        row_check(0, 32767, 0, 0, 0);
        // half-step rounding
        row_point(0, 0, 0);
        row_point(1, 2, 1);
        row_query(1);
        row_query(-1);
        row_query(3);
        // unsorted three-point table
        row_point(2, -50, 4000);
        row_cfg(ADDR_UNMAPPED, 3);
        row_query(5);
        row_cfg(ADDR_POINT_COUNT, 3);
        row_query(-20);
        row_query(1);
        row_query(-60);
        // count below range acts as two
        row_cfg(ADDR_POINT_COUNT, 0);
        row_query(7);

        foreach (dir_rows[j])
        begin
            r = dir_rows[j];
            if (r.kind == ROW_CFG)
            begin
                settle();
                write_count(r.addr, r.cnt);
            end
            else
                send_item(r.item);
        end

        for (p = 0; p < $size(phase_counts); p++)
        begin
            settle();
            write_count(ADDR_POINT_COUNT, phase_counts[p]);
            load_breakpoints();
            if (p == 0)
            begin
                // long output hold-off with back-to-back input so the block backs up
                hold_req = 1'b1;
                fill_mode = 1'b1;
            end
            for (k = 0; k < PHASE_ITEMS; k++)
            begin
                if (k == FILL_ITEMS)
                    fill_mode = 1'b0;
                send_item(random_item(eff_count(cfg_count)));
            end
        end
        settle();

        if (err_cnt == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// File: files.f
hdl/pli_pkg.sv
hdl/pli_ram.sv
hdl/pli_div.sv
hdl/piecewise_linear_interpolator_unit.sv
sim/tb_piecewise_linear_interpolator_unit.sv
